[hdl/sse_scalar_instruction_decoder_assert.svh]
// ----------------------------------------------------------------------------
// SSE scalar decoder assertion macros
// Shared assertion forms, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SSE_SCALAR_INSTRUCTION_DECODER_ASSERT_SVH
`define SSE_SCALAR_INSTRUCTION_DECODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSD_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/ssd_pkg.sv]
// ----------------------------------------------------------------------------
// SSE scalar decoder package
// Opcode and result codes, queue sizing, and the record passed from the byte
// decoder to the result builder.
// ----------------------------------------------------------------------------
`default_nettype none

package ssd_pkg;

  localparam logic [7:0] OPC_ESCAPE = 8'h0F;
  localparam logic [7:0] OPC_XORPS  = 8'h57;
  localparam logic [7:0] OPC_PFX_F2 = 8'hF2;
  localparam logic [7:0] OPC_ADDSD  = 8'h58;
  localparam logic [7:0] OPC_SUBSD  = 8'h5C;
  localparam logic [7:0] OPC_MULSD  = 8'h59;
  localparam logic [7:0] OPC_DIVSD  = 8'h5E;
  localparam logic [7:0] OPC_SQRTSD = 8'h51;
  localparam logic [7:0] OPC_MOVLD  = 8'h10;
  localparam logic [7:0] OPC_MOVST  = 8'h11;

  localparam logic [3:0] MNEM_XORPS   = 4'd0;
  localparam logic [3:0] MNEM_ADDSD   = 4'd1;
  localparam logic [3:0] MNEM_SUBSD   = 4'd2;
  localparam logic [3:0] MNEM_MULSD   = 4'd3;
  localparam logic [3:0] MNEM_DIVSD   = 4'd4;
  localparam logic [3:0] MNEM_SQRTSD  = 4'd5;
  localparam logic [3:0] MNEM_MOVLD   = 4'd6;
  localparam logic [3:0] MNEM_MOVST   = 4'd7;
  localparam logic [3:0] MNEM_UNKNOWN = 4'd8;
  localparam logic [3:0] MNEM_UNREC   = 4'd9;

  localparam logic [2:0] KIND_XMM        = 3'd0;
  localparam logic [2:0] KIND_BASE       = 3'd1;
  localparam logic [2:0] KIND_BASE_DISP  = 3'd2;
  localparam logic [2:0] KIND_BASE_IDX   = 3'd3;
  localparam logic [2:0] KIND_BIDX_DISP  = 3'd4;
  localparam logic [2:0] KIND_RIP_DISP   = 3'd5;
  localparam logic [2:0] KIND_IDX_DISP   = 3'd6;
  localparam logic [2:0] KIND_DISP       = 3'd7;

  localparam logic [1:0] MOD_NODISP = 2'd0;
  localparam logic [1:0] MOD_DISP8  = 2'd1;
  localparam logic [1:0] MOD_DISP32 = 2'd2;
  localparam logic [1:0] MOD_REG    = 2'd3;

  localparam logic [2:0] RM_SIB     = 3'd4;
  localparam logic [2:0] RM_NOBASE  = 3'd5;
  localparam logic [2:0] IDX_NONE   = 3'd4;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic        unrec;
    logic        trunc;
    logic [3:0]  op;
    logic [7:0]  modrm;
    logic [7:0]  sib;
    logic [31:0] disp;
    logic [3:0]  len;
  } rec_t;

endpackage

`default_nettype wire

[hdl/ssd_front.sv]
// ----------------------------------------------------------------------------
// SSE scalar decoder front end
// Walks the byte stream one byte per cycle while the queue has room and pushes
// one record per finished or rejected instruction, completing it with zero bytes at memory end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sse_scalar_instruction_decoder_assert.svh"

module ssd_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         byte_valid_i,
  output logic              byte_ready_o,
  input  wire logic [7:0]   code_byte_i,
  input  wire logic         memory_end_i,
  input  wire logic         q_full_i,
  output logic              push_o,
  output ssd_pkg::rec_t     rec_o
);

  typedef enum logic [2:0] {
    PH_START,
    PH_GOT0F,
    PH_GOTF2,
    PH_F20F,
    PH_MODRM,
    PH_SIB,
    PH_DISP
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  op_q, op_d;
  logic [7:0]  modrm_q, modrm_d;
  logic [7:0]  sib_q, sib_d;
  logic [31:0] disp_q, disp_d;
  logic [2:0]  left_q, left_d;
  logic [3:0]  cnt_q, cnt_d;

  logic        accept;
  logic        done;
  logic        unrec;
  logic        trunc;
  logic [2:0]  need;
  logic [2:0]  n_disp;
  logic [2:0]  left_n;
  logic [1:0]  mod_q;
  logic [1:0]  k;
  logic [31:0] disp_new;
  logic [3:0]  rec_op;
  logic [7:0]  rec_modrm;
  logic [7:0]  rec_sib;
  logic [31:0] rec_disp;

  function automatic logic [3:0] group_op(input logic [7:0] b);
    logic [3:0] r;
    case (b)
      ssd_pkg::OPC_ADDSD:  r = ssd_pkg::MNEM_ADDSD;
      ssd_pkg::OPC_SUBSD:  r = ssd_pkg::MNEM_SUBSD;
      ssd_pkg::OPC_MULSD:  r = ssd_pkg::MNEM_MULSD;
      ssd_pkg::OPC_DIVSD:  r = ssd_pkg::MNEM_DIVSD;
      ssd_pkg::OPC_SQRTSD: r = ssd_pkg::MNEM_SQRTSD;
      ssd_pkg::OPC_MOVLD:  r = ssd_pkg::MNEM_MOVLD;
      ssd_pkg::OPC_MOVST:  r = ssd_pkg::MNEM_MOVST;
      default:             r = ssd_pkg::MNEM_UNKNOWN;
    endcase
    return r;
  endfunction

  // Number of displacement bytes that follow ModRM or SIB.
  function automatic logic [2:0] disp_len(input logic [1:0] md, input logic [2:0] low);
    logic [2:0] r;
    if (md == ssd_pkg::MOD_NODISP && low == ssd_pkg::RM_NOBASE) begin
      r = 3'd4;
    end else if (md == ssd_pkg::MOD_DISP8) begin
      r = 3'd1;
    end else if (md == ssd_pkg::MOD_DISP32) begin
      r = 3'd4;
    end else begin
      r = 3'd0;
    end
    return r;
  endfunction

  assign byte_ready_o = !q_full_i;
  assign accept       = byte_valid_i && byte_ready_o;
  assign mod_q        = modrm_q[7:6];
  assign k            = (mod_q == ssd_pkg::MOD_DISP8) ? 2'd0 : 2'(3'd4 - left_q);
  assign disp_new     = disp_q | ({24'd0, code_byte_i} << {k, 3'b000});
  assign left_n       = left_q - 3'd1;

  always_comb begin
    phase_d   = phase_q;
    op_d      = op_q;
    modrm_d   = modrm_q;
    sib_d     = sib_q;
    disp_d    = disp_q;
    left_d    = left_q;
    done      = 1'b0;
    unrec     = 1'b0;
    trunc     = 1'b0;
    need      = 3'd0;
    n_disp    = 3'd0;
    rec_op    = op_q;
    rec_modrm = modrm_q;
    rec_sib   = sib_q;
    rec_disp  = disp_q;
    case (phase_q)
      PH_START: begin
        if (code_byte_i == ssd_pkg::OPC_ESCAPE || code_byte_i == ssd_pkg::OPC_PFX_F2) begin
          if (memory_end_i) begin
            unrec = 1'b1;
            trunc = 1'b1;
          end else if (code_byte_i == ssd_pkg::OPC_ESCAPE) begin
            phase_d = PH_GOT0F;
          end else begin
            phase_d = PH_GOTF2;
          end
        end else begin
          unrec = 1'b1;
        end
      end
      PH_GOT0F: begin
        if (code_byte_i == ssd_pkg::OPC_XORPS) begin
          rec_op = ssd_pkg::MNEM_XORPS;
          op_d   = ssd_pkg::MNEM_XORPS;
          if (memory_end_i) begin
            done      = 1'b1;
            trunc     = 1'b1;
            need      = 3'd1;
            rec_modrm = 8'd0;
          end else begin
            phase_d = PH_MODRM;
          end
        end else begin
          unrec = 1'b1;
        end
      end
      PH_GOTF2: begin
        if (code_byte_i == ssd_pkg::OPC_ESCAPE) begin
          if (memory_end_i) begin
            done      = 1'b1;
            trunc     = 1'b1;
            need      = 3'd2;
            rec_op    = group_op(8'd0);
            rec_modrm = 8'd0;
          end else begin
            phase_d = PH_F20F;
          end
        end else begin
          unrec = 1'b1;
        end
      end
      PH_F20F: begin
        rec_op = group_op(code_byte_i);
        op_d   = rec_op;
        if (memory_end_i) begin
          done      = 1'b1;
          trunc     = 1'b1;
          need      = 3'd1;
          rec_modrm = 8'd0;
        end else begin
          phase_d = PH_MODRM;
        end
      end
      PH_MODRM: begin
        rec_modrm = code_byte_i;
        modrm_d   = code_byte_i;
        if (code_byte_i[7:6] == ssd_pkg::MOD_REG) begin
          done = 1'b1;
        end else if (code_byte_i[2:0] == ssd_pkg::RM_SIB) begin
          if (memory_end_i) begin
            done    = 1'b1;
            trunc   = 1'b1;
            rec_sib = 8'd0;
            need    = 3'd1 + disp_len(code_byte_i[7:6], 3'd0);
          end else begin
            phase_d = PH_SIB;
          end
        end else begin
          n_disp = disp_len(code_byte_i[7:6], code_byte_i[2:0]);
          if (n_disp == 3'd0) begin
            done = 1'b1;
          end else if (memory_end_i) begin
            done  = 1'b1;
            trunc = 1'b1;
            need  = n_disp;
          end else begin
            phase_d = PH_DISP;
            left_d  = n_disp;
          end
        end
      end
      PH_SIB: begin
        rec_sib = code_byte_i;
        sib_d   = code_byte_i;
        n_disp  = disp_len(mod_q, code_byte_i[2:0]);
        if (n_disp == 3'd0) begin
          done = 1'b1;
        end else if (memory_end_i) begin
          done  = 1'b1;
          trunc = 1'b1;
          need  = n_disp;
        end else begin
          phase_d = PH_DISP;
          left_d  = n_disp;
        end
      end
      PH_DISP: begin
        rec_disp = disp_new;
        disp_d   = disp_new;
        left_d   = left_n;
        if (left_n == 3'd0) begin
          done = 1'b1;
        end else if (memory_end_i) begin
          done  = 1'b1;
          trunc = 1'b1;
          need  = left_n;
        end
      end
      default: begin
        unrec = 1'b1;
      end
    endcase
    if (done || unrec) begin
      phase_d = PH_START;
      op_d    = 4'd0;
      modrm_d = 8'd0;
      sib_d   = 8'd0;
      disp_d  = 32'd0;
      left_d  = 3'd0;
      cnt_d   = 4'd0;
    end else begin
      cnt_d   = cnt_q + 4'd1;
    end
  end

  assign push_o          = accept && (done || unrec);
  assign rec_o.unrec     = unrec;
  assign rec_o.trunc     = trunc;
  assign rec_o.op        = rec_op;
  assign rec_o.modrm     = rec_modrm;
  assign rec_o.sib       = rec_sib;
  assign rec_o.disp      = rec_disp;
  assign rec_o.len       = cnt_q + 4'd1 + {1'b0, need};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      op_q    <= 4'd0;
      modrm_q <= 8'd0;
      sib_q   <= 8'd0;
      disp_q  <= 32'd0;
      left_q  <= 3'd0;
      cnt_q   <= 4'd0;
    end else if (accept) begin
      phase_q <= phase_d;
      op_q    <= op_d;
      modrm_q <= modrm_d;
      sib_q   <= sib_d;
      disp_q  <= disp_d;
      left_q  <= left_d;
      cnt_q   <= cnt_d;
    end
  end

  `SSD_ASSERT_IMPL(a_front_len, push_o && !rec_o.unrec, rec_o.len >= 4'd3 && rec_o.len <= 4'd9, "Decoded length out of range.")

endmodule

`default_nettype wire

[hdl/ssd_fifo.sv]
// ----------------------------------------------------------------------------
// SSE scalar decoder record queue
// Short queue of decoded records between the front end and the result stage.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sse_scalar_instruction_decoder_assert.svh"

module ssd_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire ssd_pkg::rec_t  push_rec_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output ssd_pkg::rec_t       head_o
);

  ssd_pkg::rec_t                 mem_q [ssd_pkg::QDEPTH];
  logic [ssd_pkg::QPTR_W-1:0]    wr_ptr_q;
  logic [ssd_pkg::QPTR_W-1:0]    rd_ptr_q;
  logic [ssd_pkg::QCNT_W-1:0]    count_q;

  function automatic logic [ssd_pkg::QPTR_W-1:0] ptr_next(
    input logic [ssd_pkg::QPTR_W-1:0] p
  );
    logic [ssd_pkg::QPTR_W-1:0] r;
    if (p == ssd_pkg::QPTR_W'(ssd_pkg::QDEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + ssd_pkg::QPTR_W'(1);
    end
    return r;
  endfunction

  assign full_o  = (count_q == ssd_pkg::QCNT_W'(ssd_pkg::QDEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + ssd_pkg::QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - ssd_pkg::QCNT_W'(1);
      end
    end
  end

  `SSD_ASSERT_IMPL(a_fifo_bound, 1'b1, count_q <= ssd_pkg::QCNT_W'(ssd_pkg::QDEPTH), "Queue count exceeds its depth.")
  `SSD_ASSERT_NEXT(a_fifo_drain, pop_i && !push_i, count_q == $past(count_q) - ssd_pkg::QCNT_W'(1), "Queue count did not drop on pop.")

endmodule

`default_nettype wire

[hdl/ssd_back.sv]
// ----------------------------------------------------------------------------
// SSE scalar decoder result stage
// Turns a decoded record into operand fields and holds them in the output
// register until the item is taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sse_scalar_instruction_decoder_assert.svh"

module ssd_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           rec_valid_i,
  input  wire ssd_pkg::rec_t  rec_i,
  output logic                rec_pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [3:0]          mnemonic_o,
  output logic [2:0]          xmm_reg_o,
  output logic [2:0]          operand_kind_o,
  output logic [2:0]          base_reg_o,
  output logic [2:0]          index_reg_o,
  output logic [1:0]          scale_log_o,
  output logic signed [31:0]  displacement_o,
  output logic [3:0]          length_o,
  output logic                truncated_o
);

  logic        out_valid_q;
  logic [3:0]  mnem_q, mnem_d;
  logic [2:0]  reg_q, reg_d;
  logic [2:0]  kind_q, kind_d;
  logic [2:0]  base_q, base_d;
  logic [2:0]  idx_q, idx_d;
  logic [1:0]  scale_q, scale_d;
  logic [31:0] disp_q, disp_d;
  logic [3:0]  len_q, len_d;
  logic        trunc_q, trunc_d;

  logic [1:0]  md;
  logic [2:0]  rm;
  logic [2:0]  sbase;
  logic [2:0]  sidx;
  logic        has_idx;

  assign rec_pop_o = rec_valid_i && (!out_valid_q || out_ready_i);
  assign md        = rec_i.modrm[7:6];
  assign rm        = rec_i.modrm[2:0];
  assign sbase     = rec_i.sib[2:0];
  assign sidx      = rec_i.sib[5:3];
  assign has_idx   = (sidx != ssd_pkg::IDX_NONE);

  always_comb begin
    mnem_d  = rec_i.op;
    reg_d   = rec_i.modrm[5:3];
    kind_d  = ssd_pkg::KIND_XMM;
    base_d  = 3'd0;
    idx_d   = 3'd0;
    scale_d = 2'd0;
    len_d   = rec_i.len;
    trunc_d = rec_i.trunc;
    if (md == ssd_pkg::MOD_DISP8) begin
      disp_d = {{24{rec_i.disp[7]}}, rec_i.disp[7:0]};
    end else if (md == ssd_pkg::MOD_DISP32) begin
      disp_d = rec_i.disp;
    end else begin
      disp_d = 32'd0;
    end
    if (md == ssd_pkg::MOD_REG) begin
      kind_d = ssd_pkg::KIND_XMM;
      base_d = rm;
    end else if (rm == ssd_pkg::RM_SIB) begin
      if (md == ssd_pkg::MOD_NODISP && sbase == ssd_pkg::RM_NOBASE) begin
        disp_d = rec_i.disp;
        kind_d = has_idx ? ssd_pkg::KIND_IDX_DISP : ssd_pkg::KIND_DISP;
      end else if (md == ssd_pkg::MOD_NODISP) begin
        kind_d = has_idx ? ssd_pkg::KIND_BASE_IDX : ssd_pkg::KIND_BASE;
        base_d = sbase;
      end else begin
        kind_d = has_idx ? ssd_pkg::KIND_BIDX_DISP : ssd_pkg::KIND_BASE_DISP;
        base_d = sbase;
      end
      if (has_idx) begin
        idx_d   = sidx;
        scale_d = rec_i.sib[7:6];
      end
    end else if (md == ssd_pkg::MOD_NODISP && rm == ssd_pkg::RM_NOBASE) begin
      kind_d = ssd_pkg::KIND_RIP_DISP;
      disp_d = rec_i.disp;
    end else begin
      kind_d = (md == ssd_pkg::MOD_NODISP) ? ssd_pkg::KIND_BASE : ssd_pkg::KIND_BASE_DISP;
      base_d = rm;
    end
    if (rec_i.unrec) begin
      mnem_d  = ssd_pkg::MNEM_UNREC;
      reg_d   = 3'd0;
      kind_d  = ssd_pkg::KIND_XMM;
      base_d  = 3'd0;
      idx_d   = 3'd0;
      scale_d = 2'd0;
      disp_d  = 32'd0;
      len_d   = 4'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rec_pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_pop_o) begin
      mnem_q  <= mnem_d;
      reg_q   <= reg_d;
      kind_q  <= kind_d;
      base_q  <= base_d;
      idx_q   <= idx_d;
      scale_q <= scale_d;
      disp_q  <= disp_d;
      len_q   <= len_d;
      trunc_q <= trunc_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign mnemonic_o     = mnem_q;
  assign xmm_reg_o      = reg_q;
  assign operand_kind_o = kind_q;
  assign base_reg_o     = base_q;
  assign index_reg_o    = idx_q;
  assign scale_log_o    = scale_q;
  assign displacement_o = disp_q;
  assign length_o       = len_q;
  assign truncated_o    = trunc_q;

  `SSD_ASSERT_IMPL(a_back_unrec, out_valid_q && mnem_q == ssd_pkg::MNEM_UNREC, len_q == 4'd0 && kind_q == ssd_pkg::KIND_XMM, "Unrecognized item carries operand data.")
  `SSD_ASSERT_IMPL(a_back_regmode, out_valid_q && kind_q == ssd_pkg::KIND_XMM, disp_q == 32'd0 && idx_q == 3'd0 && scale_q == 2'd0, "Register operand carries memory fields.")

endmodule

`default_nettype wire

[hdl/sse_scalar_instruction_decoder.sv]
// ----------------------------------------------------------------------------
// SSE scalar instruction decoder
// Decodes xorps and the F2 0F scalar-double group from a stream of code bytes,
// walking ModRM, SIB and displacement, and reports one item per instruction.
// ----------------------------------------------------------------------------
// One code byte is accepted per clock cycle whenever the two-entry record
// queue has room, so the stream runs at one byte per cycle as long as results
// are taken. The byte that completes an instruction, or that rejects its lead
// bytes, yields a result item on the output: the front end writes the queue
// at the accepting edge, and the result stage loads its output register from
// the queue head once that register is empty or its item is being taken. The
// queue and the output register let the byte side keep running while a result
// waits to be taken.
`default_nettype none

module sse_scalar_instruction_decoder (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic [7:0]     code_byte_i,
  input  wire logic           memory_end_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [3:0]          mnemonic_o,
  output logic [2:0]          xmm_reg_o,
  output logic [2:0]          operand_kind_o,
  output logic [2:0]          base_reg_o,
  output logic [2:0]          index_reg_o,
  output logic [1:0]          scale_log_o,
  output logic signed [31:0]  displacement_o,
  output logic [3:0]          length_o,
  output logic                truncated_o
);

  logic          q_full;
  logic          q_push;
  logic          q_pop;
  logic          q_valid;
  ssd_pkg::rec_t push_rec;
  ssd_pkg::rec_t head_rec;

  ssd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (in_valid_i),
    .byte_ready_o (in_ready_o),
    .code_byte_i  (code_byte_i),
    .memory_end_i (memory_end_i),
    .q_full_i     (q_full),
    .push_o       (q_push),
    .rec_o        (push_rec)
  );

  ssd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_rec_i (push_rec),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (head_rec)
  );

  ssd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rec_valid_i    (q_valid),
    .rec_i          (head_rec),
    .rec_pop_o      (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .mnemonic_o     (mnemonic_o),
    .xmm_reg_o      (xmm_reg_o),
    .operand_kind_o (operand_kind_o),
    .base_reg_o     (base_reg_o),
    .index_reg_o    (index_reg_o),
    .scale_log_o    (scale_log_o),
    .displacement_o (displacement_o),
    .length_o       (length_o),
    .truncated_o    (truncated_o)
  );

endmodule

`default_nettype wire
